@@ design/i2cbc_pkg.sv @@
// Shared types and constants for the I2C bus clear controller.
`default_nettype none
package i2cbc_pkg;

    // Event codes carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_NONE    = 2'd0,
        FUNC_SUCCESS = 2'd1,
        FUNC_FAILURE = 2'd2,
        FUNC_UNUSED  = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FAILURE_THRESHOLD = 2'd0,
        CFG_HALF_PERIOD_TICKS = 2'd1,
        CFG_MAX_CLOCK_PULSES  = 2'd2,
        CFG_UNUSED            = 2'd3
    } t_cfg_index;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned THR_W      = 8;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned PULSE_W    = 4;

    localparam logic [THR_W-1:0]   THR_RESET   = 8'd5;
    localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd5;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 4'd9;

    localparam logic [THR_W-1:0]   FAIL_COUNT_MAX = 8'd255;
    localparam logic [PULSE_W-1:0] PULSE_COUNT_MAX = 4'd15;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 24;

    // Bit positions in the output word
    localparam int unsigned OB_SCL_LOW  = 0;
    localparam int unsigned OB_SDA_LOW  = 1;
    localparam int unsigned OB_BUSY     = 2;
    localparam int unsigned OB_FINISHED = 3;
    localparam int unsigned OB_RECOVER  = 4;
    localparam int unsigned OB_PULSES   = 5;
    localparam int unsigned OB_FAILRUN  = 9;

endpackage
`default_nettype wire

@@ design/i2c_bus_clear_controller_unit.sv @@
// Top level of the I2C bus clear controller: failure counting and recovery sequencer.
//
// Usage: each input word on the s-side stream is one time tick. tuser carries
// the transfer outcome of the tick (none, success, failure) and tdata bit 0 the
// sampled SDA level. For every accepted tick exactly one word leaves on the
// m-side stream with the SCL/SDA pull-low controls, busy, finished, recovered,
// the pulse count of the current or last clear and the current failure run.
// The tick is folded into the sequencer state and its
// result is captured in the output register at the same edge. Throughput is
// one tick per cycle, set by the single output register; o_s_tready stays high
// while the output register is empty or being drained in the same cycle.
// When the receiver stalls, the output word holds and no new tick is taken,
// so the sequencer timing advances only with accepted ticks.
// Configuration writes use the cfg channel (index 0 threshold, 1 half period,
// 2 pulse limit); the channel is always ready and unknown indexes are dropped.
// Reset (synchronous, active low) loads the default configuration, clears the
// failure count and returns the sequencer to idle with an empty output stage.
`default_nettype none
module i2c_bus_clear_controller_unit #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // tdata: [0] sda_level, [7:1] zero
    input  wire  [i2cbc_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // tuser: [1:0] func
    input  wire  [i2cbc_pkg::IN_USER_W-1:0]      i_s_tuser,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] finished,
    // [4] recovered, [8:5] pulses_sent, [16:9] failure_run, [23:17] zero
    output logic [i2cbc_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [1:0]                           i_cfg_index,
    input  wire  [i2cbc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned LIM_W = (TIMER_WIDTH > i2cbc_pkg::HALF_W) ?
                                    TIMER_WIDTH : i2cbc_pkg::HALF_W;
    localparam logic [LIM_W-1:0] TIMER_MAX = LIM_W'({TIMER_WIDTH{1'b1}});

    typedef enum logic [2:0] {
        PH_IDLE, PH_SCL_LOW, PH_SCL_HIGH, PH_STOP_SETUP, PH_STOP_HOLD, PH_STOP_RELEASE
    } t_phase;

    // Configuration registers
    logic [i2cbc_pkg::THR_W-1:0]   r_thr;
    logic [i2cbc_pkg::HALF_W-1:0]  r_half;
    logic [i2cbc_pkg::PULSE_W-1:0] r_max_pulses;

    // Sequencer state
    t_phase                        r_phase, n_phase;
    logic [TIMER_WIDTH-1:0]        r_timer, n_timer;
    logic [i2cbc_pkg::PULSE_W-1:0] r_pulses, n_pulses;
    logic [i2cbc_pkg::THR_W-1:0]   r_fail, n_fail;
    logic                          r_freed, n_freed;

    // Output stage
    logic                          r_out_valid;
    logic [i2cbc_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                          s_accept;
    i2cbc_pkg::t_func              func;
    logic                          sda;
    logic [i2cbc_pkg::THR_W-1:0]   thr_eff;
    logic [i2cbc_pkg::THR_W-1:0]   fail_inc;
    logic [i2cbc_pkg::PULSE_W-1:0] pulse_lim;
    logic [i2cbc_pkg::PULSE_W-1:0] pulse_inc;
    logic [LIM_W-1:0]              half_ext;
    logic [LIM_W-1:0]              phase_lim;
    logic [TIMER_WIDTH-1:0]        timer_inc;
    logic                          phase_end;
    t_phase                        cur_phase;
    logic                          scl_low, sda_low, busy, fin, rec;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign func = i2cbc_pkg::t_func'(i_s_tuser);
    assign sda  = i_s_tdata[0];

    // Clamp configuration values to their working ranges
    assign thr_eff   = (r_thr == '0) ? i2cbc_pkg::THR_W'(1) : r_thr;
    assign pulse_lim = (r_max_pulses == '0) ? i2cbc_pkg::PULSE_W'(1) : r_max_pulses;
    assign half_ext  = LIM_W'(r_half);
    always_comb begin
        if (half_ext == '0) begin
            phase_lim = LIM_W'(1);
        end else if (half_ext > TIMER_MAX) begin
            phase_lim = TIMER_MAX;
        end else begin
            phase_lim = half_ext;
        end
    end

    assign fail_inc  = (r_fail != i2cbc_pkg::FAIL_COUNT_MAX) ? r_fail + 1'b1 : r_fail;
    assign pulse_inc = (r_pulses != i2cbc_pkg::PULSE_COUNT_MAX) ? r_pulses + 1'b1 : r_pulses;

    // Fold one tick into the state and build its result
    always_comb begin
        n_fail    = r_fail;
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_pulses  = r_pulses;
        n_freed   = r_freed;
        cur_phase = r_phase;
        scl_low   = 1'b0;
        sda_low   = 1'b0;
        busy      = 1'b0;
        fin       = 1'b0;
        rec       = 1'b0;
        timer_inc = '0;
        phase_end = 1'b0;

        // Failure counting while idle; threshold hit starts the clear this tick
        if (r_phase == PH_IDLE) begin
            if (func == i2cbc_pkg::FUNC_SUCCESS) begin
                n_fail = '0;
            end else if (func == i2cbc_pkg::FUNC_FAILURE) begin
                if (fail_inc >= thr_eff) begin
                    n_fail    = '0;
                    cur_phase = PH_SCL_LOW;
                    n_timer   = '0;
                    n_pulses  = '0;
                    n_freed   = 1'b0;
                end else begin
                    n_fail = fail_inc;
                end
            end
        end

        n_phase = cur_phase;

        // Run the clear sequence
        if (cur_phase != PH_IDLE) begin
            busy      = 1'b1;
            scl_low   = (cur_phase == PH_SCL_LOW);
            sda_low   = (cur_phase == PH_STOP_SETUP) || (cur_phase == PH_STOP_HOLD);
            timer_inc = n_timer + 1'b1;
            phase_end = LIM_W'(timer_inc) >= phase_lim;
            n_timer   = timer_inc;
            if (phase_end) begin
                n_timer = '0;
                case (cur_phase)
                    PH_SCL_LOW: begin
                        n_phase = PH_SCL_HIGH;
                    end
                    PH_SCL_HIGH: begin
                        n_pulses = pulse_inc;
                        if (sda) begin
                            n_freed = 1'b1;
                            n_phase = PH_STOP_SETUP;
                        end else if (pulse_inc >= pulse_lim) begin
                            n_phase = PH_IDLE;
                            fin     = 1'b1;
                        end else begin
                            n_phase = PH_SCL_LOW;
                        end
                    end
                    PH_STOP_SETUP: begin
                        n_phase = PH_STOP_HOLD;
                    end
                    PH_STOP_HOLD: begin
                        n_phase = PH_STOP_RELEASE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        fin     = 1'b1;
                        rec     = n_freed;
                    end
                endcase
            end
        end

        n_out_data = '0;
        n_out_data[i2cbc_pkg::OB_SCL_LOW]  = scl_low;
        n_out_data[i2cbc_pkg::OB_SDA_LOW]  = sda_low;
        n_out_data[i2cbc_pkg::OB_BUSY]     = busy;
        n_out_data[i2cbc_pkg::OB_FINISHED] = fin;
        n_out_data[i2cbc_pkg::OB_RECOVER]  = rec;
        n_out_data[i2cbc_pkg::OB_PULSES +: i2cbc_pkg::PULSE_W] = n_pulses;
        n_out_data[i2cbc_pkg::OB_FAILRUN +: i2cbc_pkg::THR_W]  = n_fail;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= i2cbc_pkg::THR_RESET;
            r_half       <= i2cbc_pkg::HALF_RESET;
            r_max_pulses <= i2cbc_pkg::PULSE_RESET;
        end else if (i_cfg_valid) begin
            case (i2cbc_pkg::t_cfg_index'(i_cfg_index))
                i2cbc_pkg::CFG_FAILURE_THRESHOLD: r_thr <= i_cfg_data[i2cbc_pkg::THR_W-1:0];
                i2cbc_pkg::CFG_HALF_PERIOD_TICKS: r_half <= i_cfg_data;
                i2cbc_pkg::CFG_MAX_CLOCK_PULSES:
                    r_max_pulses <= i_cfg_data[i2cbc_pkg::PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold state and the output word; advance on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_pulses    <= '0;
            r_fail      <= '0;
            r_freed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_phase     <= n_phase;
                r_timer     <= n_timer;
                r_pulses    <= n_pulses;
                r_fail      <= n_fail;
                r_freed     <= n_freed;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload needs no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

@@ design/i2cbc_checker.sv @@
// Port-level checker for the I2C bus clear controller, bound to the top level.
`default_nettype none
module i2cbc_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire [i2cbc_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input wire                                  o_m_tvalid,
    input wire                                  i_m_tready
);

    // Stalled output word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // Finished only inside a clear
    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[i2cbc_pkg::OB_FINISHED] |-> o_m_tdata[i2cbc_pkg::OB_BUSY])
        else $error("finished without busy");

    // Recovered only with finished
    a_rec_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[i2cbc_pkg::OB_RECOVER] |-> o_m_tdata[i2cbc_pkg::OB_FINISHED])
        else $error("recovered without finished");

    // SCL and SDA never pulled together, and only during a clear
    a_pull_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[i2cbc_pkg::OB_SCL_LOW] && o_m_tdata[i2cbc_pkg::OB_SDA_LOW]))
        else $error("SCL and SDA pulled low together");

    a_pull_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[i2cbc_pkg::OB_BUSY] |->
            !o_m_tdata[i2cbc_pkg::OB_SCL_LOW] && !o_m_tdata[i2cbc_pkg::OB_SDA_LOW])
        else $error("line pulled low outside a clear");

endmodule

bind i2c_bus_clear_controller_unit i2cbc_checker u_i2cbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
`default_nettype wire
